/* rtl/mtep_pkg.sv */
// Package: shared types and constants of the MIDI track event parser.
package mtep_pkg;

  // Longest length quantity decoded, in bytes (1 to 4).
  localparam int unsigned VLQ_MAX_BYTES = 4;

  localparam logic [7:0] ST_META       = 8'hFF;
  localparam logic [7:0] ST_SYSEX      = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
  localparam logic [3:0] HI_NOTE_ON    = 4'h9;
  localparam logic [3:0] HI_POLY_PRESS = 4'hA;
  localparam logic [3:0] HI_CONTROL    = 4'hB;
  localparam logic [3:0] HI_PITCH_BEND = 4'hE;
  localparam logic [27:0] TEMPO_LEN    = 28'd3;

  localparam logic KIND_NOTE  = 1'b0;
  localparam logic KIND_TEMPO = 1'b1;

  typedef enum logic [2:0] {
    PH_DELTA  = 3'd0,
    PH_STATUS = 3'd1,
    PH_MTYPE  = 3'd2,
    PH_LEN    = 3'd3,
    PH_TEMPO  = 3'd4,
    PH_SKIP   = 3'd5,
    PH_DATA1  = 3'd6,
    PH_DATA2  = 3'd7
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  run_status;
    logic [31:0] tick_total;
    logic [27:0] vlq_value;
    logic [1:0]  vlq_count;
    logic [27:0] skip_remaining;
    logic [7:0]  event_status;
    logic [7:0]  first_data;
    logic [7:0]  meta_kind;
    logic [23:0] tempo_gather;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:          PH_DELTA,
    run_status:     8'd0,
    tick_total:     32'd0,
    vlq_value:      28'd0,
    vlq_count:      2'd0,
    skip_remaining: 28'd0,
    event_status:   8'd0,
    first_data:     8'd0,
    meta_kind:      8'd0,
    tempo_gather:   24'd0
  };

  typedef struct packed {
    logic        valid;
    logic        event_kind;
    logic [31:0] event_tick;
    logic [7:0]  note_number;
    logic [7:0]  note_velocity;
    logic [23:0] tempo_micros;
  } event_result_t;

endpackage

/* rtl/mtep_ifs.sv */
// Interfaces: byte input channel and event result channel.
interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       track_start;

  modport source (output valid, output data_byte, output track_start, input ready);
  modport sink   (input valid, input data_byte, input track_start, output ready);
endinterface

interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic        event_kind;
  logic [31:0] event_tick;
  logic [7:0]  note_number;
  logic [7:0]  note_velocity;
  logic [23:0] tempo_micros;

  modport source (output valid, output event_kind, output event_tick, output note_number,
                  output note_velocity, output tempo_micros, input ready);
  modport sink   (input valid, input event_kind, input event_tick, input note_number,
                  input note_velocity, input tempo_micros, output ready);
endinterface

/* rtl/midi_track_event_parser_core.sv */
// Top level: byte-serial MIDI track event parser with registered input and result.
//
//  channel  direction  handshake      payload
//  in_if    sink       valid/ready    data_byte[7:0], track_start
//  out_if   source     valid/ready    event_kind, event_tick[31:0], note_number[7:0],
//                                     note_velocity[7:0], tempo_micros[23:0]
//
// One byte per cycle sustained unless a result is held; a byte's event follows the input and result registers.
// The parse step sits between the input register and the result register; the
// parser state updates as the registered byte moves into the result stage.
// Synchronous active-low reset returns the parser to the delta-time phase with zero state.
// A held result stalls the input register only; input ready drops once both are full.
module midi_track_event_parser_core (
  input logic        clk,
  input logic        rst_n,
  mtep_in_if.sink    in_if,
  mtep_out_if.source out_if
);
  import mtep_pkg::*;

  logic          s1_valid_r;
  logic [7:0]    s1_byte_r;
  logic          s1_start_r;
  parse_state_t  state_r;
  parse_state_t  state_nxt;
  event_result_t step_res;
  event_result_t out_r;
  logic          out_free;
  logic          s1_fire;

  assign out_free    = !out_r.valid || out_if.ready;
  assign s1_fire     = s1_valid_r && out_free;
  assign in_if.ready = !s1_valid_r || out_free;

  mtep_step u_step (
    .state_i     (state_r),
    .data_byte   (s1_byte_r),
    .track_start (s1_start_r),
    .state_o     (state_nxt),
    .result_o    (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_byte_r  <= in_if.data_byte;
      s1_start_r <= in_if.track_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  // hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (out_free) begin
      out_r.valid <= s1_fire && step_res.valid;
    end
    if (s1_fire && step_res.valid) begin
      out_r.event_kind    <= step_res.event_kind;
      out_r.event_tick    <= step_res.event_tick;
      out_r.note_number   <= step_res.note_number;
      out_r.note_velocity <= step_res.note_velocity;
      out_r.tempo_micros  <= step_res.tempo_micros;
    end
  end

  assign out_if.valid         = out_r.valid;
  assign out_if.event_kind    = out_r.event_kind;
  assign out_if.event_tick    = out_r.event_tick;
  assign out_if.note_number   = out_r.note_number;
  assign out_if.note_velocity = out_r.note_velocity;
  assign out_if.tempo_micros  = out_r.tempo_micros;

  a_tempo_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.event_kind == KIND_TEMPO)
      |-> (out_if.note_number == 8'd0 && out_if.note_velocity == 8'd0))
    else $error("tempo event carries note fields");

  a_note_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.event_kind == KIND_NOTE)
      |-> (out_if.note_velocity != 8'd0 && out_if.tempo_micros == 24'd0))
    else $error("note event with zero velocity or tempo data");

  a_tick_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !s1_start_r) |=> (state_r.tick_total >= $past(state_r.tick_total)))
    else $error("tick total decreased within a track");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.ready && s1_valid_r) |-> !in_if.ready)
    else $error("input taken while both stages are held");

endmodule

/* rtl/mtep_step.sv */
// Parse step: next parser state and optional event for one track byte.
module mtep_step (
  input  mtep_pkg::parse_state_t  state_i,
  input  logic [7:0]              data_byte,
  input  logic                    track_start,
  output mtep_pkg::parse_state_t  state_o,
  output mtep_pkg::event_result_t result_o
);
  import mtep_pkg::*;

  parse_state_t cur;
  logic         is_status;
  logic [7:0]   st;
  logic [27:0]  vlq_shift;
  logic [2:0]   count_inc;
  logic         vlq_more;
  logic [32:0]  tick_sum;
  logic [27:0]  skip_dec;
  logic         tempo_len;
  logic         two_byte;

  always_comb begin
    cur       = track_start ? STATE_RESET : state_i;
    is_status = data_byte[7];
    st        = is_status ? data_byte : cur.run_status;
    vlq_shift = {cur.vlq_value[20:0], data_byte[6:0]};
    count_inc = {1'b0, cur.vlq_count} + 3'd1;
    vlq_more  = data_byte[7] && (count_inc < 3'(VLQ_MAX_BYTES));
    tick_sum  = {1'b0, cur.tick_total} + {5'd0, vlq_shift};
    skip_dec  = cur.skip_remaining - 28'd1;
    tempo_len = (cur.event_status == ST_META) && (cur.meta_kind == META_TEMPO)
                && (vlq_shift == TEMPO_LEN);
    two_byte  = (st[7:4] == HI_NOTE_OFF) || (st[7:4] == HI_NOTE_ON)
                || (st[7:4] == HI_POLY_PRESS) || (st[7:4] == HI_CONTROL)
                || (st[7:4] == HI_PITCH_BEND);

    state_o  = cur;
    result_o = '0;

    case (cur.phase)
      PH_DELTA: begin
        if (vlq_more) begin
          state_o.vlq_value = vlq_shift;
          state_o.vlq_count = count_inc[1:0];
        end else begin
          state_o.tick_total = tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0];
          state_o.vlq_value  = 28'd0;
          state_o.vlq_count  = 2'd0;
          state_o.phase      = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (is_status) state_o.run_status = data_byte;
        state_o.event_status = st;
        state_o.vlq_value    = 28'd0;
        state_o.vlq_count    = 2'd0;
        if (st == ST_META) begin
          if (is_status) begin
            state_o.phase = PH_MTYPE;
          end else begin
            state_o.meta_kind = data_byte;
            state_o.phase     = PH_LEN;
          end
        end else if (two_byte) begin
          if (is_status) begin
            state_o.phase = PH_DATA1;
          end else begin
            state_o.first_data = data_byte;
            state_o.phase      = PH_DATA2;
          end
        end else if ((st == ST_SYSEX) || (st == ST_SYSEX_ESC)) begin
          // a data byte here is a complete one-byte length
          if (is_status) begin
            state_o.phase = PH_LEN;
          end else if (data_byte[6:0] == 7'd0) begin
            state_o.phase = PH_DELTA;
          end else begin
            state_o.skip_remaining = {21'd0, data_byte[6:0]};
            state_o.phase          = PH_SKIP;
          end
        end else begin
          if (is_status) begin
            state_o.skip_remaining = 28'd1;
            state_o.phase          = PH_SKIP;
          end else begin
            state_o.phase = PH_DELTA;
          end
        end
      end
      PH_MTYPE: begin
        state_o.meta_kind = data_byte;
        state_o.vlq_value = 28'd0;
        state_o.vlq_count = 2'd0;
        state_o.phase     = PH_LEN;
      end
      PH_LEN: begin
        if (vlq_more) begin
          state_o.vlq_value = vlq_shift;
          state_o.vlq_count = count_inc[1:0];
        end else begin
          state_o.vlq_value = 28'd0;
          state_o.vlq_count = 2'd0;
          if (tempo_len) begin
            state_o.tempo_gather   = 24'd0;
            state_o.skip_remaining = TEMPO_LEN;
            state_o.phase          = PH_TEMPO;
          end else if (vlq_shift == 28'd0) begin
            state_o.phase = PH_DELTA;
          end else begin
            state_o.skip_remaining = vlq_shift;
            state_o.phase          = PH_SKIP;
          end
        end
      end
      PH_TEMPO: begin
        state_o.tempo_gather   = {cur.tempo_gather[15:0], data_byte};
        state_o.skip_remaining = skip_dec;
        if (skip_dec == 28'd0) begin
          result_o.valid        = 1'b1;
          result_o.event_kind   = KIND_TEMPO;
          result_o.event_tick   = cur.tick_total;
          result_o.tempo_micros = {cur.tempo_gather[15:0], data_byte};
          state_o.phase         = PH_DELTA;
        end
      end
      PH_SKIP: begin
        state_o.skip_remaining = skip_dec;
        if (skip_dec == 28'd0) state_o.phase = PH_DELTA;
      end
      PH_DATA1: begin
        state_o.first_data = data_byte;
        state_o.phase      = PH_DATA2;
      end
      PH_DATA2: begin
        // note-on with zero velocity counts as note-off: drop it
        if ((cur.event_status[7:4] == HI_NOTE_ON) && (data_byte != 8'd0)) begin
          result_o.valid         = 1'b1;
          result_o.event_kind    = KIND_NOTE;
          result_o.event_tick    = cur.tick_total;
          result_o.note_number   = cur.first_data;
          result_o.note_velocity = data_byte;
        end
        state_o.phase = PH_DELTA;
      end
      default: begin
        state_o.phase = PH_DELTA;
      end
    endcase
  end

endmodule

/* tb/sv/testbench.sv */
// Testbench for midi_track_event_parser_core: directed track bytes, then random tracks.
`timescale 1ns / 100ps

module testbench;
  import mtep_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 1100;
  localparam int CALM_TAIL    = 200;

  localparam logic [3:0] HI_PROG_CHANGE = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;
  localparam logic [7:0] SYS_FIRST      = 8'hF1;
  localparam logic [7:0] SYS_LAST       = 8'hFE;

  typedef struct packed {
    logic        kind;
    logic [31:0] tick;
    logic [7:0]  note;
    logic [7:0]  vel;
    logic [23:0] tempo;
  } midi_event_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    logic        typed;
    midi_event_t ev;
  } stim_row_t;

  localparam midi_event_t NO_EVENT = '0;

  // Events are typed in only where they are obvious; other rows go through the predictor.
  localparam stim_row_t DIRECTED [0:32] = '{
    {8'h00, 1'b1, 1'b0, NO_EVENT},   // new track, zero delta
    {8'h90, 1'b0, 1'b0, NO_EVENT},
    {8'h3C, 1'b0, 1'b0, NO_EVENT},
    {8'h7F, 1'b0, 1'b1, {KIND_NOTE, 32'd0, 8'h3C, 8'h7F, 24'd0}},
    {8'h81, 1'b0, 1'b0, NO_EVENT},   // two-byte delta of 128
    {8'h00, 1'b0, 1'b0, NO_EVENT},
    {8'h40, 1'b0, 1'b0, NO_EVENT},   // running status note-on
    {8'h00, 1'b0, 1'b0, NO_EVENT},   // velocity zero: nothing reported
    {8'hFF, 1'b0, 1'b0, NO_EVENT},   // over-long delta, cut after four bytes
    {8'hFF, 1'b0, 1'b0, NO_EVENT},
    {8'hFF, 1'b0, 1'b0, NO_EVENT},
    {8'hFF, 1'b0, 1'b0, NO_EVENT},
    {8'hFF, 1'b0, 1'b0, NO_EVENT},   // meta status
    {8'h51, 1'b0, 1'b0, NO_EVENT},
    {8'h03, 1'b0, 1'b0, NO_EVENT},
    {8'hFF, 1'b0, 1'b0, NO_EVENT},
    {8'hFF, 1'b0, 1'b0, NO_EVENT},
    {8'hFF, 1'b0, 1'b1, {KIND_TEMPO, 32'h1000_007F, 8'h00, 8'h00, 24'hFF_FFFF}},
    {8'h00, 1'b0, 1'b0, NO_EVENT},
    {8'h00, 1'b0, 1'b0, NO_EVENT},   // running meta, type byte only
    {8'h00, 1'b0, 1'b0, NO_EVENT},   // zero length meta
    {8'h00, 1'b0, 1'b0, NO_EVENT},
    {8'hF0, 1'b0, 1'b0, NO_EVENT},   // sysex, one byte skipped
    {8'h01, 1'b0, 1'b0, NO_EVENT},
    {8'hF7, 1'b0, 1'b0, NO_EVENT},
    {8'h00, 1'b0, 1'b0, NO_EVENT},
    {8'hB0, 1'b0, 1'b0, NO_EVENT},
    {8'h07, 1'b1, 1'b0, NO_EVENT},   // restart mid-event
    {8'h00, 1'b0, 1'b0, NO_EVENT},   // data byte with no status seen yet
    {8'h00, 1'b0, 1'b0, NO_EVENT},
    {8'h9F, 1'b0, 1'b0, NO_EVENT},
    {8'hFF, 1'b0, 1'b0, NO_EVENT},
    {8'hFF, 1'b0, 1'b1, {KIND_NOTE, 32'd7, 8'hFF, 8'hFF, 24'd0}}
  };

  logic clk = 1'b0;
  logic rst_n;

  mtep_in_if  in_ch ();
  mtep_out_if out_ch ();

  midi_track_event_parser_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #5 clk = ~clk;

  stim_row_t   feed_q[$];
  midi_event_t event_q[$];
  int          feed_idx     = 0;
  int          fault_count  = 0;
  int          quiet_cycles = 0;
  int          cycle_no     = 0;
  int          gap_left     = 0;
  int          stall_left   = 0;
  bit          next_start;
  logic [7:0]  gen_running;

  // Parser image
  phase_t      trk_phase;
  logic [7:0]  trk_running;
  logic [31:0] trk_ticks;
  logic [27:0] len_acc;
  logic [1:0]  len_bytes;
  logic [27:0] bytes_left;
  logic [7:0]  cur_status;
  logic [7:0]  first_byte;
  logic [7:0]  meta_type;
  logic [23:0] tempo_acc;

  function void clear_parser();
    trk_phase   = PH_DELTA;
    trk_running = '0;
    trk_ticks   = '0;
    len_acc     = '0;
    len_bytes   = '0;
    bytes_left  = '0;
    cur_status  = '0;
    first_byte  = '0;
    meta_type   = '0;
    tempo_acc   = '0;
  endfunction

  // Shift one byte into the length accumulator; true once the quantity is complete.
  function bit feed_length(input logic [7:0] b);
    int unsigned n;
    n = len_bytes + 1;
    len_acc = {len_acc[20:0], b[6:0]};
    if (b[7] && n < VLQ_MAX_BYTES) begin
      len_bytes = n[1:0];
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function void close_length();
    logic [27:0] len;
    len = len_acc;
    len_acc = '0;
    len_bytes = '0;
    if (cur_status == ST_META && meta_type == META_TEMPO && len == TEMPO_LEN) begin
      tempo_acc = '0;
      bytes_left = TEMPO_LEN;
      trk_phase = PH_TEMPO;
    end else if (len == '0) begin
      trk_phase = PH_DELTA;
    end else begin
      bytes_left = len;
      trk_phase = PH_SKIP;
    end
  endfunction

  function bit parse_track_byte(input logic [7:0] b, input logic start, output midi_event_t ev);
    logic [32:0] sum;
    logic [7:0]  st;
    logic [3:0]  hi;
    bit          is_st;
    bit          hit;
    ev = NO_EVENT;
    hit = 1'b0;
    if (start) clear_parser();
    case (trk_phase)
      PH_DELTA: begin
        if (feed_length(b)) begin
          sum = {1'b0, trk_ticks} + {5'd0, len_acc};
          trk_ticks = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          len_acc = '0;
          len_bytes = '0;
          trk_phase = PH_STATUS;
        end
      end
      PH_STATUS: begin
        is_st = b[7];
        if (is_st) trk_running = b;
        st = trk_running;
        cur_status = st;
        hi = st[7:4];
        len_acc = '0;
        len_bytes = '0;
        if (st == ST_META) begin
          if (is_st) begin
            trk_phase = PH_MTYPE;
          end else begin
            meta_type = b;
            trk_phase = PH_LEN;
          end
        end else if (hi == HI_NOTE_OFF || hi == HI_NOTE_ON || hi == HI_POLY_PRESS ||
                     hi == HI_CONTROL || hi == HI_PITCH_BEND) begin
          if (is_st) begin
            trk_phase = PH_DATA1;
          end else begin
            first_byte = b;
            trk_phase = PH_DATA2;
          end
        end else if (st == ST_SYSEX || st == ST_SYSEX_ESC) begin
          trk_phase = PH_LEN;
          // a bare data byte here is already the first length byte
          if (!is_st) begin
            if (feed_length(b)) close_length();
          end
        end else if (is_st) begin
          bytes_left = 28'd1;
          trk_phase = PH_SKIP;
        end else begin
          trk_phase = PH_DELTA;
        end
      end
      PH_MTYPE: begin
        meta_type = b;
        len_acc = '0;
        len_bytes = '0;
        trk_phase = PH_LEN;
      end
      PH_LEN: begin
        if (feed_length(b)) close_length();
      end
      PH_TEMPO: begin
        tempo_acc = {tempo_acc[15:0], b};
        bytes_left = bytes_left - 28'd1;
        if (bytes_left == '0) begin
          ev = {KIND_TEMPO, trk_ticks, 8'h00, 8'h00, tempo_acc};
          hit = 1'b1;
          trk_phase = PH_DELTA;
        end
      end
      PH_SKIP: begin
        bytes_left = bytes_left - 28'd1;
        if (bytes_left == '0) trk_phase = PH_DELTA;
      end
      PH_DATA1: begin
        first_byte = b;
        trk_phase = PH_DATA2;
      end
      default: begin
        if (cur_status[7:4] == HI_NOTE_ON && b != 8'h00) begin
          ev = {KIND_NOTE, trk_ticks, first_byte, b, 24'd0};
          hit = 1'b1;
        end
        trk_phase = PH_DELTA;
      end
    endcase
    return hit;
  endfunction

  // Random track generation
  function void push_byte(input logic [7:0] b);
    feed_q.push_back({b, next_start, 1'b0, NO_EVENT});
    next_start = 1'b0;
  endfunction

  function void push_vlq(input logic [27:0] v);
    int          n;
    logic [27:0] sh;
    n = 1;
    if (v >= 28'h80) n = 2;
    if (v >= 28'h4000) n = 3;
    if (v >= 28'h20_0000) n = 4;
    for (int i = n - 1; i >= 0; i--) begin
      sh = v >> (7 * i);
      push_byte({i != 0, sh[6:0]});
    end
  endfunction

  function logic [7:0] rand_data(input bit bare);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (bare || $urandom_range(0, 3) != 0) b[7] = 1'b0;
    return b;
  endfunction

  function logic [27:0] random_delta(input bit huge);
    int r;
    if (huge) return 28'($urandom_range(32'h0FFF_FFFF, 32'h0F00_0000));
    r = $urandom_range(0, 9);
    if (r < 2) return 28'd0;
    if (r < 6) return 28'($urandom_range(0, 127));
    if (r < 8) return 28'($urandom_range(128, 16383));
    if (r < 9) return 28'($urandom_range(16384, 32'h1F_FFFF));
    return 28'($urandom_range(32'h20_0000, 32'h0FFF_FFFF));
  endfunction

  // Emit a status byte, or leave it out when running status allows; true when left out.
  function bit put_status(input logic [7:0] st, input bit may_omit);
    bit bare;
    bare = may_omit && st == gen_running && $urandom_range(0, 1) == 1;
    if (!bare) push_byte(st);
    gen_running = st;
    return bare;
  endfunction

  function logic [27:0] random_len();
    if ($urandom_range(0, 19) == 0) return 28'($urandom_range(128, 160));
    return 28'($urandom_range(0, 6));
  endfunction

  // One event after its delta; false when the track is cut short here.
  function bit put_event();
    int          pick;
    logic [3:0]  hi;
    logic [3:0]  chan;
    logic [7:0]  st;
    logic [7:0]  kind_byte;
    logic [27:0] n;
    bit          bare;
    pick = $urandom_range(0, 99);
    chan = 4'($urandom_range(0, 15));
    if (pick < 55) begin
      if (pick < 35) begin
        hi = HI_NOTE_ON;
      end else begin
        case ($urandom_range(0, 3))
          0: hi = HI_NOTE_OFF;
          1: hi = HI_POLY_PRESS;
          2: hi = HI_CONTROL;
          default: hi = HI_PITCH_BEND;
        endcase
      end
      bare = put_status({hi, chan}, 1'b1);
      push_byte(rand_data(bare));
      push_byte(($urandom_range(0, 7) == 0) ? 8'h00 : rand_data(1'b0));
    end else if (pick < 65) begin
      if (pick < 62) begin
        st = {($urandom_range(0, 1) == 1) ? HI_PROG_CHANGE : HI_CHAN_PRESS, chan};
      end else begin
        st = 8'($urandom_range(SYS_FIRST, SYS_LAST));
        if (st == ST_SYSEX_ESC) st = SYS_FIRST;
      end
      bare = put_status(st, 1'b1);
      push_byte(rand_data(bare));
    end else if (pick < 78) begin
      void'(put_status(ST_META, 1'b1));
      push_byte(META_TEMPO);
      push_vlq(TEMPO_LEN);
      repeat (3) push_byte(8'($urandom_range(0, 255)));
    end else if (pick < 86) begin
      bare = put_status(ST_META, 1'b1);
      kind_byte = rand_data(bare);
      n = random_len();
      if (kind_byte == META_TEMPO && n == TEMPO_LEN) n = 28'd4;
      push_byte(kind_byte);
      push_vlq(n);
      repeat (n) push_byte(8'($urandom_range(0, 255)));
    end else if (pick < 94) begin
      n = random_len();
      void'(put_status(($urandom_range(0, 1) == 1) ? ST_SYSEX : ST_SYSEX_ESC, n < 28'd128));
      push_vlq(n);
      repeat (n) push_byte(8'($urandom_range(0, 255)));
    end else if (pick < 98) begin
      // broken sequence: stray bytes, running status no longer trusted
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
      gen_running = 8'h00;
    end else begin
      push_byte({HI_NOTE_ON, chan});
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function void gen_track();
    bit huge;
    bit going;
    int events;
    gen_running = 8'h00;
    next_start = 1'b1;
    huge = ($urandom_range(0, 11) == 0);
    events = huge ? $urandom_range(20, 40) : $urandom_range(3, 30);
    going = 1'b1;
    for (int e = 0; e < events && going; e++) begin
      push_vlq(random_delta(huge));
      going = put_event();
    end
  endfunction

  function bit no_idle_window();
    return feed_idx > feed_q.size() - CALM_TAIL || (cycle_no % 256) >= 192;
  endfunction

  // Byte source: predict on each transaction, then present the next byte or a gap.
  always @(posedge clk) begin : byte_source
    midi_event_t ev;
    bit          hit;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        hit = parse_track_byte(feed_q[feed_idx].data, feed_q[feed_idx].start, ev);
        if (feed_q[feed_idx].typed) event_q.push_back(feed_q[feed_idx].ev);
        else if (hit) event_q.push_back(ev);
        feed_idx++;
      end
      // hold a byte that has not been taken yet
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (feed_idx >= feed_q.size()) begin
          in_ch.valid <= 1'b0;
        end else if (gap_left > 0) begin
          in_ch.valid <= 1'b0;
          gap_left--;
        end else if (!no_idle_window() && $urandom_range(0, 5) == 0) begin
          in_ch.valid <= 1'b0;
          gap_left = $urandom_range(0, 2);
        end else begin
          in_ch.valid       <= 1'b1;
          in_ch.data_byte   <= feed_q[feed_idx].data;
          in_ch.track_start <= feed_q[feed_idx].start;
        end
      end
    end
  end

  // Event sink: compare each transaction with the oldest predicted event.
  always @(posedge clk) begin : event_sink
    midi_event_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (event_q.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected event: kind=%0d tick=%0h note=%0h vel=%0h tempo=%0h",
                     out_ch.event_kind, out_ch.event_tick, out_ch.note_number,
                     out_ch.note_velocity, out_ch.tempo_micros);
        end else begin
          want = event_q.pop_front();
          if (out_ch.event_kind !== want.kind || out_ch.event_tick !== want.tick ||
              out_ch.note_number !== want.note || out_ch.note_velocity !== want.vel ||
              out_ch.tempo_micros !== want.tempo) begin
            fault_count++;
            if (fault_count <= 10)
              $display("event mismatch: expected kind=%0d tick=%0h note=%0h vel=%0h",
                       want.kind, want.tick, want.note, want.vel,
                       " tempo=%0h, got kind=%0d tick=%0h note=%0h vel=%0h tempo=%0h",
                       want.tempo, out_ch.event_kind, out_ch.event_tick,
                       out_ch.note_number, out_ch.note_velocity, out_ch.tempo_micros);
          end
        end
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!no_idle_window() && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_no++;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.data_byte   = 8'h00;
    in_ch.track_start = 1'b0;
    out_ch.ready      = 1'b0;
    clear_parser();
    foreach (DIRECTED[i]) feed_q.push_back(DIRECTED[i]);
    while (feed_q.size() < $size(DIRECTED) + RANDOM_BYTES) gen_track();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while ((feed_idx < feed_q.size() || event_q.size() != 0) && quiet_cycles < QUIET_LIMIT)
      @(posedge clk);
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      fault_count += event_q.size();
      if (fault_count == 0)
        $display("Verification passed");
      else
        $display("Verification failed");
    end
    $finish;
  end

endmodule
